/* hw/rtl/mltrq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mltrq_pkg
// Shared widths, codes and types of the multi-lane timed release queue.
// ----------------------------------------------------------------------------
package mltrq_pkg;

    localparam int KEY_W       = 32;
    localparam int ID_W        = 16;
    localparam int CNT_W       = 4;
    localparam int LANE_OUT_W  = 3;
    localparam int KIND_W      = 2;
    localparam int MAX_LANES_DEF  = 8;
    localparam int LANE_DEPTH_DEF = 16;
    localparam int LANE_LIMIT_CAP = 8;
    localparam logic [CNT_W-1:0] LANE_COUNT_RST = 4'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DROP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    // Input operations
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Per-cycle command to the cells of one lane
    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctrl_t;

endpackage

/* hw/rtl/mltrq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mltrq_cell
// One slot of a sorted lane: holds a key/id pair and trades with neighbors.
// ----------------------------------------------------------------------------
module mltrq_cell
    import mltrq_pkg::*;
#(
    parameter bit IS_FIRST = 1'b0
)
(
    input  logic             clk,
    input  cell_ctrl_t       ctrl,
    input  logic [KEY_W-1:0] new_key,
    input  logic [ID_W-1:0]  new_id,
    input  logic             occ,
    input  logic             prev_occ,
    input  logic [KEY_W-1:0] prev_key,
    input  logic [ID_W-1:0]  prev_id,
    input  logic [KEY_W-1:0] next_key,
    input  logic [ID_W-1:0]  next_id,
    output logic [KEY_W-1:0] key,
    output logic [ID_W-1:0]  id
);

    logic [KEY_W-1:0] key_reg, key_next;
    logic [ID_W-1:0]  id_reg, id_next;
    logic             prev_le;
    logic             prev_gt;
    logic             own_gt;

    // Insert compares against this slot and the one before it
    always_comb
    begin
        prev_le  = IS_FIRST || (prev_occ && (prev_key <= new_key));
        prev_gt  = !IS_FIRST && prev_occ && (prev_key > new_key);
        own_gt   = !occ || (key_reg > new_key);
        key_next = key_reg;
        id_next  = id_reg;
        if (ctrl.pop)
        begin
            key_next = next_key;
            id_next  = next_id;
        end
        else if (ctrl.ins)
        begin
            if (prev_gt)
            begin
                key_next = prev_key;
                id_next  = prev_id;
            end
            else if (prev_le && own_gt)
            begin
                key_next = new_key;
                id_next  = new_id;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        id_reg  <= id_next;
    end

    assign key = key_reg;
    assign id  = id_reg;

endmodule

/* hw/rtl/mltrq_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mltrq_lane
// A lane: a row of cells kept in ascending key order, plus its fill count.
// ----------------------------------------------------------------------------
module mltrq_lane
    import mltrq_pkg::*;
#(
    parameter int LANE_DEPTH = LANE_DEPTH_DEF,
    parameter int FW = $clog2(LANE_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [KEY_W-1:0] new_key,
    input  logic [ID_W-1:0]  new_id,
    output logic [KEY_W-1:0] head_key,
    output logic [ID_W-1:0]  head_id,
    output logic [FW-1:0]    fill
);

    logic [FW-1:0]    fill_reg, fill_next;
    logic [KEY_W-1:0] keys [LANE_DEPTH];
    logic [ID_W-1:0]  ids  [LANE_DEPTH];
    logic             occ  [LANE_DEPTH];

    // Fill count
    always_comb
    begin
        fill_next = fill_reg;
        if (ctrl.pop)
            fill_next = fill_reg - FW'(1);
        else if (ctrl.ins)
            fill_next = fill_reg + FW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    // Row of cells
    for (genvar i = 0; i < LANE_DEPTH; i++)
    begin : g_cell
        assign occ[i] = (FW'(i) < fill_reg);

        mltrq_cell #(
            .IS_FIRST (i == 0)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .new_key  (new_key),
            .new_id   (new_id),
            .occ      (occ[i]),
            .prev_occ (occ[(i == 0) ? 0 : i - 1]),
            .prev_key (keys[(i == 0) ? 0 : i - 1]),
            .prev_id  (ids[(i == 0) ? 0 : i - 1]),
            .next_key (keys[(i == LANE_DEPTH - 1) ? i : i + 1]),
            .next_id  (ids[(i == LANE_DEPTH - 1) ? i : i + 1]),
            .key      (keys[i]),
            .id       (ids[i])
        );
    end

    assign head_key = keys[0];
    assign head_id  = ids[0];
    assign fill     = fill_reg;

endmodule

/* hw/rtl/multi_lane_timed_release_queue_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_lane_timed_release_queue_top
// Round-robin lanes of sorted cells; inserts place in order, ticks release
// due heads in lane order.
// ----------------------------------------------------------------------------
// Insert: result registered the next cycle; next item taken then unless out_stall holds it.
// Tick: the due heads are sampled first, then one release per cycle unless out_stall holds
//   the output, one per due lane (at most the lanes in use); one lane pop per cycle.
// Reset: all lanes empty, next lane 0, lane count 2; no clearing pass.
// ----------------------------------------------------------------------------
module multi_lane_timed_release_queue_top
    import mltrq_pkg::*;
#(
    parameter int MAX_LANES  = MAX_LANES_DEF,
    parameter int LANE_DEPTH = LANE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CNT_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  op,
    input  logic [KEY_W-1:0]      entry_key,
    input  logic [ID_W-1:0]       entry_id,
    input  logic [KEY_W-1:0]      now_time,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [KIND_W-1:0]     kind,
    output logic [LANE_OUT_W-1:0] lane,
    output logic [ID_W-1:0]       out_id,
    output logic [KEY_W-1:0]      out_key,
    output logic                  last,
    output logic                  all_empty
);

    localparam int LW = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
    localparam int FW = $clog2(LANE_DEPTH + 1);
    localparam int HW = $clog2(MAX_LANES * LANE_DEPTH + 1);
    localparam int CW = 6;
    localparam int LIMIT = (MAX_LANES < LANE_LIMIT_CAP) ? MAX_LANES : LANE_LIMIT_CAP;

    typedef enum logic { ST_IDLE, ST_SCAN } state_t;

    state_t                  state_reg;
    logic [CNT_W-1:0]        lane_count_reg;
    logic [LW-1:0]           next_lane_reg;
    logic [HW-1:0]           held_reg;
    logic [MAX_LANES-1:0]    due_reg;

    logic                    out_valid_reg;
    logic [KIND_W-1:0]       kind_reg;
    logic [LANE_OUT_W-1:0]   lane_reg;
    logic [ID_W-1:0]         id_reg;
    logic [KEY_W-1:0]        key_reg;
    logic                    last_reg;
    logic                    empty_reg;

    logic [KEY_W-1:0]        head_key [MAX_LANES];
    logic [ID_W-1:0]         head_id  [MAX_LANES];
    logic [FW-1:0]           fill     [MAX_LANES];
    cell_ctrl_t              ctrl     [MAX_LANES];

    logic [CW-1:0]           n_eff;
    logic                    out_ok;
    logic                    accept;
    logic [LW-1:0]           ins_lane;
    logic                    ins_full;
    logic [MAX_LANES-1:0]    due_now;
    logic [MAX_LANES-1:0]    pick;
    logic [LW-1:0]           pick_idx;
    logic [MAX_LANES-1:0]    due_left;
    logic                    do_pop;
    logic                    do_ins;
    logic [HW-1:0]           held_next;

    // Lanes in use
    always_comb
    begin
        if (lane_count_reg == '0)
            n_eff = CW'(1);
        else if (CW'(lane_count_reg) > CW'(LIMIT))
            n_eff = CW'(LIMIT);
        else
            n_eff = CW'(lane_count_reg);
    end

    assign out_ok    = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || !out_ok;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Insert target
    always_comb
    begin
        ins_lane = (CW'(next_lane_reg) < n_eff) ? next_lane_reg : '0;
        ins_full = (fill[ins_lane] == FW'(LANE_DEPTH));
        do_ins   = accept && (op == OP_INSERT) && !ins_full;
    end

    // Due heads at tick time, lowest due lane during the scan
    always_comb
    begin
        for (int l = 0; l < MAX_LANES; l++)
        begin
            due_now[l] = (CW'(l) < n_eff) && (fill[l] != '0) && (head_key[l] <= now_time);
        end
        pick     = due_reg & (~due_reg + MAX_LANES'(1));
        pick_idx = '0;
        for (int l = 0; l < MAX_LANES; l++)
        begin
            if (pick[l])
                pick_idx = LW'(l);
        end
        due_left = due_reg & ~pick;
        do_pop   = (state_reg == ST_SCAN) && out_ok;
    end

    // Lane commands
    always_comb
    begin
        for (int l = 0; l < MAX_LANES; l++)
        begin
            ctrl[l].ins = do_ins && (ins_lane == LW'(l));
            ctrl[l].pop = do_pop && pick[l];
        end
    end

    always_comb
    begin
        held_next = held_reg;
        if (do_ins)
            held_next = held_reg + HW'(1);
        else if (do_pop)
            held_next = held_reg - HW'(1);
    end

    for (genvar g = 0; g < MAX_LANES; g++)
    begin : g_lane
        mltrq_lane #(
            .LANE_DEPTH (LANE_DEPTH),
            .FW         (FW)
        ) u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl[g]),
            .new_key  (entry_key),
            .new_id   (entry_id),
            .head_key (head_key[g]),
            .head_id  (head_id[g]),
            .fill     (fill[g])
        );
    end

    // Control and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            lane_count_reg <= LANE_COUNT_RST;
            next_lane_reg  <= '0;
            held_reg       <= '0;
            due_reg        <= '0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= KIND_ACCEPT;
            lane_reg       <= '0;
            id_reg         <= '0;
            key_reg        <= '0;
            last_reg       <= 1'b0;
            empty_reg      <= 1'b1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                lane_count_reg <= cfg_data;
            held_reg <= held_next;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (op == OP_INSERT))
                    begin
                        next_lane_reg <= (CW'(ins_lane) + CW'(1) >= n_eff) ?
                                         '0 : ins_lane + LW'(1);
                        out_valid_reg <= 1'b1;
                        kind_reg      <= ins_full ? KIND_DROP : KIND_ACCEPT;
                        lane_reg      <= LANE_OUT_W'(ins_lane);
                        id_reg        <= entry_id;
                        key_reg       <= entry_key;
                        last_reg      <= 1'b1;
                        empty_reg     <= (held_next == '0);
                    end
                    else if (accept && (op == OP_TICK) && (due_now != '0))
                    begin
                        due_reg   <= due_now;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (do_pop)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= KIND_RELEASE;
                        lane_reg      <= LANE_OUT_W'(pick_idx);
                        id_reg        <= head_id[pick_idx];
                        key_reg       <= head_key[pick_idx];
                        last_reg      <= (due_left == '0);
                        empty_reg     <= (held_next == '0);
                        due_reg       <= due_left;
                        if (due_left == '0)
                            state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign lane      = lane_reg;
    assign out_id    = id_reg;
    assign out_key   = key_reg;
    assign last      = last_reg;
    assign all_empty = empty_reg;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-lane timed release queue: directed and
// random inserts and ticks over several lane counts, checked beat by beat
// against a sorted-lane predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top;
    import mltrq_pkg::*;

    localparam int NLANE = MAX_LANES_DEF;
    localparam int DEPTH = LANE_DEPTH_DEF;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        logic            op;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] now;
    } req_t;

    typedef struct {
        logic [KIND_W-1:0]     kind;
        logic [LANE_OUT_W-1:0] lane;
        logic [ID_W-1:0]       id;
        logic [KEY_W-1:0]      key;
        logic                  last;
        logic                  empty;
    } rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic op = OP_INSERT;
    logic [KEY_W-1:0] entry_key = '0;
    logic [ID_W-1:0] entry_id = '0;
    logic [KEY_W-1:0] now_time = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [KIND_W-1:0] kind;
    logic [LANE_OUT_W-1:0] lane;
    logic [ID_W-1:0] out_id;
    logic [KEY_W-1:0] out_key;
    logic last;
    logic all_empty;

    multi_lane_timed_release_queue_top u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .op(op),
        .entry_key(entry_key), .entry_id(entry_id), .now_time(now_time),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .lane(lane),
        .out_id(out_id), .out_key(out_key), .last(last), .all_empty(all_empty)
    );

    always #4 clk = ~clk;

    // predictor state
    logic [KEY_W-1:0] lane_keys [NLANE][DEPTH];
    logic [ID_W-1:0]  lane_ids  [NLANE][DEPTH];
    int unsigned lane_fill [NLANE];
    int unsigned rr_lane = 0;
    int unsigned held = 0;
    logic [CNT_W-1:0] lane_cnt_reg = LANE_COUNT_RST;

    req_t pending_q [$];
    rsp_t expected_q [$];
    req_t cur_req;
    int errors = 0;
    int n_items = 0, n_results = 0, n_drops = 0, n_releases = 0;
    bit quiet = 0;
    logic [KEY_W-1:0] tnow = 32'd100;

    function automatic int unsigned lanes_active();
        int unsigned c;
        c = 32'(lane_cnt_reg);
        if (c == 0) c = 1;
        if (c > LANE_LIMIT_CAP) c = LANE_LIMIT_CAP;
        return c;
    endfunction

    // advance the queue model by one accepted beat, queue the outcomes
    function automatic void queue_model_step(req_t r);
        int unsigned n, ln, pos, k;
        rsp_t e;
        n = lanes_active();
        if (r.op == OP_INSERT)
        begin
            ln = (rr_lane < n) ? rr_lane : 0;
            rr_lane = (ln + 1 >= n) ? 0 : ln + 1;
            e.lane = LANE_OUT_W'(ln); e.id = r.id; e.key = r.key; e.last = 1'b1;
            if (lane_fill[ln] >= DEPTH)
            begin
                e.kind = KIND_DROP;
            end
            else
            begin
                pos = lane_fill[ln];
                while (pos > 0 && lane_keys[ln][pos-1] > r.key)
                begin
                    lane_keys[ln][pos] = lane_keys[ln][pos-1];
                    lane_ids[ln][pos] = lane_ids[ln][pos-1];
                    pos--;
                end
                lane_keys[ln][pos] = r.key;
                lane_ids[ln][pos] = r.id;
                lane_fill[ln]++;
                held++;
                e.kind = KIND_ACCEPT;
            end
            e.empty = (held == 0);
            expected_q.push_back(e);
        end
        else
        begin
            k = expected_q.size();
            for (int l = 0; l < n; l++)
            begin
                if (lane_fill[l] != 0 && lane_keys[l][0] <= r.now)
                begin
                    e.kind = KIND_RELEASE; e.lane = LANE_OUT_W'(l);
                    e.key = lane_keys[l][0]; e.id = lane_ids[l][0];
                    for (int s = 1; s < lane_fill[l]; s++)
                    begin
                        lane_keys[l][s-1] = lane_keys[l][s];
                        lane_ids[l][s-1] = lane_ids[l][s];
                    end
                    lane_fill[l]--;
                    held--;
                    e.last = 1'b0;
                    e.empty = (held == 0);
                    expected_q.push_back(e);
                end
            end
            if (expected_q.size() > k) expected_q[expected_q.size()-1].last = 1'b1;
        end
    endfunction

    // sender: feeds beats from pending_q, random gap bursts
    int in_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        logic nv;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            nv = in_valid;
            if (in_valid && !in_stall)
            begin
                queue_model_step(cur_req);
                n_items++;
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (in_gap > 0) in_gap--;
                else if (!quiet && $urandom_range(0, 6) == 0) in_gap = $urandom_range(0, 7);
                else if (pending_q.size() != 0)
                begin
                    cur_req = pending_q.pop_front();
                    op <= cur_req.op;
                    entry_key <= cur_req.key;
                    entry_id <= cur_req.id;
                    now_time <= cur_req.now;
                    nv = 1'b1;
                end
            end
            in_valid <= nv;
        end
    end

    // receiver: random stall bursts, one long hold-off, result check
    int out_gap = 0;
    bit long_done = 0;
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t e;
        logic ns;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                n_results++;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat kind %0d lane %0d id %h key %h",
                             $time, kind, lane, out_id, out_key);
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.kind == KIND_DROP) n_drops++;
                    if (e.kind == KIND_RELEASE) n_releases++;
                    if (kind !== e.kind || lane !== e.lane || out_id !== e.id ||
                        out_key !== e.key || last !== e.last || all_empty !== e.empty)
                    begin
                        $display("%0t: mismatch exp kind %0d lane %0d id %h key %h",
                                 $time, e.kind, e.lane, e.id, e.key);
                        $display("%0t:          exp last %b empty %b",
                                 $time, e.last, e.empty);
                        $display("%0t:          got kind %0d lane %0d id %h key %h",
                                 $time, kind, lane, out_id, out_key);
                        $display("%0t:          got last %b empty %b",
                                 $time, last, all_empty);
                        errors++;
                    end
                end
            end
            // long hold-off once, midway through the run
            if (!long_done && n_results == 150)
            begin
                long_done = 1;
                out_gap = 300;
            end
            if (out_gap > 0)
            begin
                out_gap--;
                ns = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_gap = $urandom_range(0, 7);
                ns = 1'b1;
            end
            else ns = 1'b0;
            out_stall <= ns;
        end
    end

    // watchdog on cycles with no beat on either side
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no progress for %0d cycles", STALL_LIMIT);
            $display("multi_lane_timed_release_queue_top test failed");
            $finish;
        end
        else idle_cycles <= idle_cycles + 1;
    end

    task automatic add_insert(logic [KEY_W-1:0] k, logic [ID_W-1:0] i);
        req_t r;
        r.op = OP_INSERT; r.key = k; r.id = i; r.now = $urandom;
        pending_q.push_back(r);
    endtask

    task automatic add_tick(logic [KEY_W-1:0] t);
        req_t r;
        r.op = OP_TICK; r.now = t; r.key = $urandom; r.id = ID_W'($urandom);
        pending_q.push_back(r);
    endtask

    // wait until every beat is out, then let the block settle
    task automatic drain();
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_lane_count(logic [CNT_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        lane_cnt_reg = v;
        cfg_valid <= 1'b0;
    endtask

    // random mix: keys clustered near a moving time so ties and releases are common
    task automatic add_random(int n);
        for (int i = 0; i < n; i++)
        begin
            tnow = tnow + $urandom_range(0, 4);
            case ($urandom_range(0, 9))
                0:       add_insert($urandom, ID_W'($urandom));
                1:       add_tick($urandom);
                2, 3, 4: add_tick(tnow + $urandom_range(0, 20));
                default: add_insert(tnow + $urandom_range(0, 30), ID_W'($urandom));
            endcase
        end
    endtask

    initial
    begin
        for (int l = 0; l < NLANE; l++) lane_fill[l] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, equal keys, ticks with nothing due, at the reset count
        add_tick(32'd0);
        add_insert(32'd0, 16'h0000);
        add_insert(32'hFFFF_FFFF, 16'hFFFF);
        add_insert(32'd5, 16'h0001);
        add_insert(32'd5, 16'h0002);
        add_insert(32'd5, 16'h0003);
        add_insert(32'd5, 16'h0004);
        add_insert(32'd3, 16'h0005);
        add_tick(32'd0);
        add_tick(32'd4);
        add_tick(32'd5);
        add_tick(32'hFFFF_FFFE);
        add_tick(32'hFFFF_FFFF);
        add_tick(32'hFFFF_FFFF);
        drain();

        // one lane: fill past its depth so inserts get dropped
        write_lane_count(4'd1);
        for (int i = 0; i < 18; i++) add_insert(KEY_W'(40 - (i % 5)), ID_W'(16'h100 + i));
        add_tick(32'd37);
        add_tick(32'd40);
        add_insert(32'hFFFF_FFFF, 16'hAAAA);
        add_random(40);
        drain();

        // full lane count; long hold-off lands in here
        write_lane_count(4'd8);
        add_random(110);
        // shrink while the round-robin pointer may sit past the new count
        write_lane_count(4'd3);
        add_random(60);
        write_lane_count(4'd0);
        add_random(50);
        write_lane_count(4'd15);
        add_tick(32'hFFFF_FFFF);
        add_random(60);
        write_lane_count(4'd5);
        quiet = 1;
        add_random(60);
        add_tick(32'hFFFF_FFFF);
        add_tick(32'hFFFF_FFFF);
        drain();
        repeat (20) @(posedge clk);

        $display("covered %0d input beats, %0d results (%0d releases, %0d drops)",
                 n_items, n_results, n_releases, n_drops);
        $display("lane counts 2, 1, 8, 3, 0, 15, 5 with stalls on both sides");
        if (errors == 0 && expected_q.size() == 0)
            $display("multi_lane_timed_release_queue_top test passed");
        else
            $display("multi_lane_timed_release_queue_top test failed");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/mltrq_pkg.sv
hw/rtl/mltrq_cell.sv
hw/rtl/mltrq_lane.sv
hw/rtl/multi_lane_timed_release_queue_top.sv
test/tb_top.sv
